/* sv/running_median_add_remove_macros.svh */
// Assertion macros used by the running median datapath.
`ifndef RUNNING_MEDIAN_ADD_REMOVE_MACROS_SVH
`define RUNNING_MEDIAN_ADD_REMOVE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rma_pkg.sv */
// Package: sizes, status codes, controller states and command structs.
`default_nettype none
package rma_pkg;
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int MED_W    = VAL_W + 1;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEL,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic apply;   // update the cell chain with the accepted beat
        logic select;  // capture the middle cells
        logic load;    // sum and load the output register
    } cmd_t;

    typedef struct packed {
        logic out_busy; // output register holds a beat not yet taken
    } stat_t;
endpackage
`default_nettype wire

/* sv/rma_if.sv */
// Stream interfaces for the input and result channels.
`default_nettype none
interface rma_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [31:0]         value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface rma_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic signed [32:0]         median_doubled;
    logic [8:0]                 element_count;

    modport source (output valid, status, median_doubled, element_count, input ready);
    modport sink   (input valid, status, median_doubled, element_count, output ready);
endinterface
`default_nettype wire

/* sv/running_median_add_remove.sv */
// Top level of the running median block: controller plus datapath.
`default_nettype none
// Running median over a sorted multiset of up to 256 signed 32-bit values.
// Each input beat adds a value (func 0) or removes one copy of it (func 1);
// each beat yields exactly one result beat with a status, the count held
// afterwards and, on status ok, twice the median (sum of the two middle
// values for an even count). A failed add (store full) or a failed remove
// (value absent) leaves the store unchanged; removing the last value reports
// status empty. The values live in a chain of 256 registers kept in order:
// the cycle that accepts a beat compares all cells at once and shifts the
// chain, the next cycle captures the middle cells, and the sum state then
// adds them into the output register, waiting while that register still
// holds a result not yet taken. A new beat is accepted only once the
// previous beat is loaded; the output register lets the next beat enter
// while the previous result still waits. No clearing pass follows reset.
module running_median_add_remove (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rma_in_if.sink     in_ch,
    rma_out_if.source  out_ch
);
    rma_pkg::cmd_t  cmd;
    rma_pkg::stat_t stat;

    // Sequence apply, select and load for each beat.
    rma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the sorted cells, the count and the result register.
    rma_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .stat   (stat)
    );
endmodule
`default_nettype wire

/* sv/rma_ctrl.sv */
// Controller: sequences apply, select and sum for each accepted beat.
`default_nettype none
module rma_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  rma_pkg::stat_t     stat,
    output rma_pkg::cmd_t      cmd
);
    rma_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rma_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = rma_pkg::ST_SEL;
                end
            end
            rma_pkg::ST_SEL:
            begin
                cmd.select = 1'b1;
                state_next = rma_pkg::ST_SUM;
            end
            rma_pkg::ST_SUM:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = rma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rma_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* sv/rma_dpath.sv */
// Datapath: sorted cell chain, middle-cell select, sum and output register.
`default_nettype none
`include "running_median_add_remove_macros.svh"
module rma_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rma_in_if.sink             in_ch,
    rma_out_if.source          out_ch,
    input  rma_pkg::cmd_t      cmd,
    output rma_pkg::stat_t     stat
);
    localparam int CAP = rma_pkg::CAPACITY;

    logic signed [rma_pkg::VAL_W-1:0] cell_reg  [CAP];
    logic signed [rma_pkg::VAL_W-1:0] cell_next [CAP];
    logic [CAP-1:0]                   gt_add;
    logic [CAP-1:0]                   ge_rem;
    logic [CAP-1:0]                   eq_rem;
    logic [CAP-1:0]                   in_range;

    logic [rma_pkg::CNT_W-1:0]        count_reg;
    logic [rma_pkg::CNT_W-1:0]        count_next;
    logic [1:0]                       status_reg;
    logic [1:0]                       status_next;
    logic                             is_full;
    logic                             found;
    logic                             do_add;
    logic                             do_rem;

    logic [rma_pkg::IDX_W-1:0]        half;
    logic [rma_pkg::IDX_W-1:0]        idx_a;
    logic signed [rma_pkg::VAL_W-1:0] sel_a_reg;
    logic signed [rma_pkg::VAL_W-1:0] sel_b_reg;
    logic signed [rma_pkg::MED_W-1:0] sum;

    logic                             out_valid_reg;
    logic [1:0]                       out_status_reg;
    logic signed [rma_pkg::MED_W-1:0] out_med_reg;
    logic [rma_pkg::CNT_W-1:0]        out_count_reg;

    // Compare every held cell against the incoming value in parallel.
    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cmp
            assign in_range[g] = rma_pkg::CNT_W'(g) < count_reg;
            assign gt_add[g]   = in_range[g] && (cell_reg[g] > in_ch.value);
            assign ge_rem[g]   = in_range[g] && (cell_reg[g] >= in_ch.value);
            assign eq_rem[g]   = in_range[g] && (cell_reg[g] == in_ch.value);
        end
    endgenerate

    assign is_full = count_reg == rma_pkg::CNT_W'(CAP);
    assign found   = |eq_rem;
    assign do_add  = cmd.apply && (in_ch.func == rma_pkg::FUNC_ADD) && !is_full;
    assign do_rem  = cmd.apply && (in_ch.func == rma_pkg::FUNC_REMOVE) && found;

    // Insert after equal copies (shift right), or close the gap at the first
    // cell not below the value (shift left).
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            always_comb
            begin
                cell_next[g] = cell_reg[g];
                if (do_add)
                begin
                    if (gt_add[g])
                    begin
                        if (g == 0)
                        begin
                            cell_next[g] = in_ch.value;
                        end
                        else
                        begin
                            cell_next[g] = gt_add[(g == 0) ? 0 : g - 1]
                                         ? cell_reg[(g == 0) ? 0 : g - 1] : in_ch.value;
                        end
                    end
                    else if (rma_pkg::CNT_W'(g) == count_reg)
                    begin
                        // first free cell takes the top cell when the chain shifts
                        cell_next[g] = ((g > 0) && gt_add[(g == 0) ? 0 : g - 1])
                                     ? cell_reg[(g == 0) ? 0 : g - 1] : in_ch.value;
                    end
                end
                else if (do_rem && ge_rem[g] && (g < CAP - 1))
                begin
                    cell_next[g] = cell_reg[(g < CAP - 1) ? g + 1 : g];
                end
            end

            always_ff @(posedge clk)
            begin
                cell_reg[g] <= cell_next[g];
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (cmd.apply)
        begin
            priority if (in_ch.func == rma_pkg::FUNC_ADD)
            begin
                if (is_full)
                begin
                    status_next = rma_pkg::STAT_FULL;
                end
                else
                begin
                    count_next  = count_reg + rma_pkg::CNT_W'(1);
                    status_next = rma_pkg::STAT_OK;
                end
            end
            else if (!found)
            begin
                status_next = rma_pkg::STAT_NOT_FOUND;
            end
            else
            begin
                count_next  = count_reg - rma_pkg::CNT_W'(1);
                status_next = (count_reg == rma_pkg::CNT_W'(1))
                            ? rma_pkg::STAT_EMPTY : rma_pkg::STAT_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // Middle cells: one for an odd count, two neighbors for an even count.
    assign half  = rma_pkg::IDX_W'(count_reg >> 1);
    assign idx_a = count_reg[0] ? half : half - rma_pkg::IDX_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            sel_a_reg <= cell_reg[idx_a];
            sel_b_reg <= cell_reg[half];
        end
    end

    assign sum = {sel_a_reg[rma_pkg::VAL_W-1], sel_a_reg}
               + {sel_b_reg[rma_pkg::VAL_W-1], sel_b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_status_reg <= status_reg;
            out_med_reg    <= (status_reg == rma_pkg::STAT_OK) ? sum : '0;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.out_busy         = out_valid_reg && !out_ch.ready;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.median_doubled = out_med_reg;
    assign out_ch.element_count  = out_count_reg;

    `RMA_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= rma_pkg::CNT_W'(CAP), "count above capacity")
    `RMA_ASSERT_NEXT(a_load_valid, cmd.load, out_valid_reg, "load did not raise valid")
    `RMA_ASSERT_NOW(a_ok_nonempty, out_valid_reg && (out_status_reg == rma_pkg::STAT_OK),
        out_count_reg != '0, "ok result with empty store")
    `RMA_ASSERT_NOW(a_no_overwrite, cmd.load, !(out_valid_reg && !out_ch.ready),
        "output overwritten while waiting")
endmodule
`default_nettype wire

/* test/testbench.sv */
// Testbench for the running median block: directed and random add/remove beats.
`default_nettype none
module testbench;
    typedef struct packed {
        logic [1:0]         status;
        logic signed [32:0] median_doubled;
        logic [8:0]         element_count;
    } median_result_t;

    logic clk;
    logic rst_n;

    rma_in_if  in_ch ();
    rma_out_if out_ch ();

    running_median_add_remove u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Shadow copy of the sorted store, kept ascending.
    logic signed [31:0] shadow_values[$];
    median_result_t     expected_results[$];
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 failures;
    int                 idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the result of one beat and update the shadow store.
    function automatic median_result_t predict_median(logic func, logic signed [31:0] value);
        median_result_t r;
        int             n;
        int             pos;
        int             hit;
        r = '0;
        hit = -1;
        if (func == rma_pkg::FUNC_ADD)
        begin
            if (shadow_values.size() >= rma_pkg::CAPACITY)
            begin
                r.status = rma_pkg::STAT_FULL;
                r.element_count = 9'(shadow_values.size());
                return r;
            end
            // Insert after any equal copies.
            pos = shadow_values.size();
            while (pos > 0 && shadow_values[pos - 1] > value)
                pos--;
            shadow_values.insert(pos, value);
        end
        else
        begin
            foreach (shadow_values[i])
                if (hit < 0 && shadow_values[i] == value)
                    hit = i;
            if (hit < 0)
            begin
                r.status = rma_pkg::STAT_NOT_FOUND;
                r.element_count = 9'(shadow_values.size());
                return r;
            end
            shadow_values.delete(hit);
            if (shadow_values.size() == 0)
            begin
                r.status = rma_pkg::STAT_EMPTY;
                return r;
            end
        end
        n = shadow_values.size();
        r.status = rma_pkg::STAT_OK;
        r.element_count = 9'(n);
        if (n % 2 == 1)
            r.median_doubled = 33'(shadow_values[n / 2]) <<< 1;
        else
            r.median_doubled = 33'(shadow_values[n / 2 - 1]) + 33'(shadow_values[n / 2]);
        return r;
    endfunction

    // Drive one beat, hold it until accepted, then drop valid.
    task automatic send_beat(logic func, logic signed [31:0] value);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
            @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.func  = func;
        in_ch.value = value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_results.insert(expected_results.size(), predict_median(func, value));
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Receiver stall: at each falling edge drive ready low at random, recv_idle_pct percent of the time.
    always @(negedge clk)
        if (rst_n)
            out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        median_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d med=%0d cnt=%0d", $time,
                         out_ch.status, out_ch.median_doubled, out_ch.element_count);
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_ch.status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, out_ch.status);
                    failures++;
                end
                if (out_ch.median_doubled !== exp_r.median_doubled)
                begin
                    $display("%0t: median_doubled expected %0d actual %0d", $time,
                             exp_r.median_doubled, out_ch.median_doubled);
                    failures++;
                end
                if (out_ch.element_count !== exp_r.element_count)
                begin
                    $display("%0t: element_count expected %0d actual %0d", $time,
                             exp_r.element_count, out_ch.element_count);
                    failures++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Pick a value from the held set, or noise.
    function automatic logic signed [31:0] pick_value(int pool);
        if (shadow_values.size() > 0 && $urandom_range(99, 0) < 70)
            return shadow_values[$urandom_range(shadow_values.size() - 1, 0)];
        if (pool > 0)
            return $signed(32'($urandom_range(pool, 0)) - 32'(pool / 2));
        return $signed($urandom());
    endfunction

    // Extremes, both operations and the not-found and empty cases.
    task automatic test_directed();
        send_beat(rma_pkg::FUNC_REMOVE, 32'sd5);                // remove from an empty set
        send_beat(rma_pkg::FUNC_ADD, 32'sh7fffffff);
        send_beat(rma_pkg::FUNC_ADD, 32'sh7fffffff);            // duplicate, even count max sum
        send_beat(rma_pkg::FUNC_REMOVE, 32'sh80000000);         // absent value
        send_beat(rma_pkg::FUNC_REMOVE, 32'sh7fffffff);
        send_beat(rma_pkg::FUNC_REMOVE, 32'sh7fffffff);         // leaves set empty
        send_beat(rma_pkg::FUNC_ADD, 32'sh80000000);
        send_beat(rma_pkg::FUNC_ADD, 32'sh80000000);            // even count min sum
        send_beat(rma_pkg::FUNC_ADD, 32'sh7fffffff);
        send_beat(rma_pkg::FUNC_ADD, -32'sd1);
        send_beat(rma_pkg::FUNC_ADD, 32'sd0);
        send_beat(rma_pkg::FUNC_REMOVE, 32'sh80000000);
        send_beat(rma_pkg::FUNC_REMOVE, -32'sd1);
        send_beat(rma_pkg::FUNC_REMOVE, 32'sh55555555);
        send_beat(rma_pkg::FUNC_REMOVE, 32'shaaaaaaaa);
        while (shadow_values.size() > 0)
            send_beat(rma_pkg::FUNC_REMOVE, shadow_values[0]);
    endtask

    // Fill the store past capacity, then drain it.
    task automatic test_full_store();
        while (shadow_values.size() < rma_pkg::CAPACITY)
            send_beat(rma_pkg::FUNC_ADD, $signed($urandom()));
        send_beat(rma_pkg::FUNC_ADD, 32'sd1);
        send_beat(rma_pkg::FUNC_ADD, 32'sh80000000);
        // Hold off until every result is back.
        wait_drained();
        while (shadow_values.size() > 0)
            send_beat(rma_pkg::FUNC_REMOVE, pick_value(0));
    endtask

    // Random adds and removes with a biased walk over the set size.
    task automatic test_random(int beats);
        int pool;
        for (int i = 0; i < beats; i++)
        begin
            pool = (i / 100) % 3 == 0 ? 15 : 0;
            if ($urandom_range(99, 0) < (shadow_values.size() < 40 ? 60 : 40))
                send_beat(rma_pkg::FUNC_ADD, pick_value(pool));
            else
                send_beat(rma_pkg::FUNC_REMOVE, pick_value(pool));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        failures = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.func = rma_pkg::FUNC_ADD;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 85;
        test_directed();
        test_random(500);
        send_idle_pct = 85;
        recv_idle_pct = 18;
        test_full_store();
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
        wait_drained();
        repeat (10) @(negedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
